// ===== sv/fcm_pkg.sv =====
// Shared types, codes and widths for the FIR convolution multiply-accumulate block.
package fcm_pkg;

    localparam int MAX_TAPS_DEF    = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int KIND_W = 2;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 16;
    localparam int CFG_W  = 11;
    localparam int OUT_W  = 48;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_fcm_state;

    typedef struct packed {
        logic clear;
        logic vld;
        logic live;
    } t_mac_ctl;

endpackage

// ===== sv/fir_convolution_mac.sv =====
// Top level of the FIR convolution block: item sequencer, tap and history memories.
// A sample transfer pushes the sample into the history line and computes the sum of
// tap times delayed sample over min(tap_count, MAX_TAPS) taps with one multiply-accumulate
// unit, one tap per cycle; the input stalls from the accepted sample until its result is
// loaded into the output register, after one read per tap and then the product, accumulate
// and output stages, or with no tap reads when tap_count is zero, plus any time the
// previous result still waits downstream. Tap loads, history clears and the unused kind
// give no result and do not stall the input. A clear is immediate: a fill count marks
// which history entries hold real samples, so no clearing pass runs after reset or
// clear. Reading a tap that was never loaded gives an undefined sum.
module fir_convolution_mac #(
    parameter int MAX_TAPS    = fcm_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = fcm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [fcm_pkg::CFG_W-1:0]           i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [fcm_pkg::KIND_W-1:0]          i_kind,
    input  logic [fcm_pkg::IDX_W-1:0]           i_tap_index,
    input  logic signed [fcm_pkg::VAL_W-1:0]    i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [fcm_pkg::OUT_W-1:0]    o_out_value
);
    import fcm_pkg::*;

    localparam int AW = $clog2(MAX_TAPS);
    localparam int CW = $clog2(MAX_TAPS + 1);
    localparam int SU = (SAMPLE_BITS < VAL_W) ? SAMPLE_BITS : VAL_W;
    localparam logic [AW-1:0] LAST_POS = AW'(MAX_TAPS - 1);
    localparam logic [CW-1:0] TAPS_MAX = CW'(MAX_TAPS);

    t_fcm_state r_state, n_state;

    logic [CFG_W-1:0] r_tap_count;
    logic [CW-1:0]    r_taps, r_k, r_fill;
    logic [AW-1:0]    r_ptr, r_rd_pos;

    logic signed [VAL_W-1:0] tap_mem  [MAX_TAPS];
    logic signed [SU-1:0]    hist_mem [MAX_TAPS];

    logic signed [VAL_W-1:0] r_tap_rd;
    logic signed [SU-1:0]    r_hist_rd;
    logic                    r_s1_vld, r_s1_live;

    logic                    r_o_valid;
    logic signed [OUT_W-1:0] r_out_value;

    logic accept, is_sample, is_load, is_clear;
    logic issue, last_issue, out_free, load_out, mac_busy;
    logic [CW-1:0] taps_eff, fill_next;
    logic [31:0]   tap_idx_ext;
    logic [AW-1:0] tap_wr_addr;
    logic          tap_idx_ok;

    t_mac_ctl                mac_ctl;
    logic signed [OUT_W-1:0] mac_acc;

    assign is_sample   = (i_kind == KIND_SAMPLE);
    assign is_load     = (i_kind == KIND_LOAD);
    assign is_clear    = (i_kind == KIND_CLEAR);
    assign tap_idx_ext = 32'(i_tap_index);
    assign tap_wr_addr = tap_idx_ext[AW-1:0];
    assign tap_idx_ok  = (tap_idx_ext < 32'(MAX_TAPS));
    assign taps_eff    = (32'(r_tap_count) > 32'(MAX_TAPS)) ? TAPS_MAX : CW'(r_tap_count);
    assign fill_next   = (r_fill == TAPS_MAX) ? r_fill : r_fill + 1'b1;
    assign last_issue  = (r_k == r_taps - 1'b1);
    assign out_free    = !r_o_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && is_sample) begin
                    n_state = (taps_eff == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall  = (r_state != ST_IDLE);
        accept   = i_valid && (r_state == ST_IDLE);
        issue    = (r_state == ST_RUN);
        load_out = (r_state == ST_DRAIN) && !r_s1_vld && !mac_busy && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap_count <= CFG_W'(1);
            r_ptr       <= '0;
            r_fill      <= '0;
            r_taps      <= '0;
            r_k         <= '0;
            r_rd_pos    <= '0;
            r_s1_vld    <= 1'b0;
            r_s1_live   <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_s1_vld  <= issue;
            r_s1_live <= issue && (r_k < r_fill);
            if (i_cfg_wr_en) begin
                r_tap_count <= i_cfg_wr_data;
            end
            if (accept && is_sample) begin
                r_taps   <= taps_eff;
                r_k      <= '0;
                r_rd_pos <= r_ptr;
                r_fill   <= fill_next;
                r_ptr    <= (r_ptr == LAST_POS) ? '0 : r_ptr + 1'b1;
            end else if (accept && is_clear) begin
                r_ptr  <= '0;
                r_fill <= '0;
            end else if (issue) begin
                r_k      <= r_k + 1'b1;
                r_rd_pos <= (r_rd_pos == '0) ? LAST_POS : r_rd_pos - 1'b1;
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_load && tap_idx_ok) begin
            tap_mem[tap_wr_addr] <= i_value;
        end
        r_tap_rd <= tap_mem[r_k[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_sample) begin
            hist_mem[r_ptr] <= i_value[SU-1:0];
        end
        r_hist_rd <= hist_mem[r_rd_pos];
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_value <= mac_acc;
        end
    end

    assign mac_ctl.clear = accept && is_sample;
    assign mac_ctl.vld   = r_s1_vld;
    assign mac_ctl.live  = r_s1_live;

    fcm_mac_unit #(
        .SAMPLE_W (SU)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mac_ctl),
        .i_tap    (r_tap_rd),
        .i_sample (r_hist_rd),
        .o_acc    (mac_acc),
        .o_busy   (mac_busy)
    );

    assign o_valid     = r_o_valid;
    assign o_out_value = r_out_value;

endmodule

// ===== sv/fcm_mac_unit.sv =====
// Shared multiply-accumulate unit: one registered product and one accumulator.
module fcm_mac_unit #(
    parameter int SAMPLE_W = fcm_pkg::VAL_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fcm_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [fcm_pkg::VAL_W-1:0]    i_tap,
    input  logic signed [SAMPLE_W-1:0]          i_sample,
    output logic signed [fcm_pkg::OUT_W-1:0]    o_acc,
    output logic                                o_busy
);
    import fcm_pkg::*;

    localparam int PW = VAL_W + SAMPLE_W;

    logic                    r_p_vld;
    logic signed [PW-1:0]    r_prod;
    logic signed [OUT_W-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.live) begin
            r_prod <= i_tap * i_sample;
        end else begin
            r_prod <= '0;
        end
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_p_vld) begin
            r_acc <= r_acc + OUT_W'(r_prod);
        end
    end

    assign o_acc  = r_acc;
    assign o_busy = r_p_vld;

endmodule

// ===== sv/fcm_checker.sv =====
// Port-level checker for the FIR convolution block and its bind to the top level.
module fcm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic [fcm_pkg::KIND_W-1:0]          i_kind,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [fcm_pkg::OUT_W-1:0]    o_out_value
);
    import fcm_pkg::*;

    logic in_xfer;
    assign in_xfer = i_valid && !o_stall;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("Block not idle after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_value))
        else $error("Stalled result changed or was dropped.");

    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_kind == KIND_SAMPLE) |=> o_stall)
        else $error("Input not stalled while a sample is being convolved.");

    a_other_oneshot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_kind != KIND_SAMPLE) |=> !o_stall)
        else $error("Non-sample transfer did not finish in one cycle.");

endmodule

bind fir_convolution_mac fcm_checker u_fcm_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the FIR convolution multiply-accumulate block.
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_TAPS       = fcm_pkg::MAX_TAPS_DEF;
    localparam int RANDOM_ITEMS   = 580;
    localparam int QUIET_TAIL     = 60;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 20000;

    localparam logic [fcm_pkg::KIND_W-1:0] KIND_IGNORED = 2'd3;

    typedef struct packed {
        bit                                cfg;
        logic [fcm_pkg::CFG_W-1:0]         taps;
        logic [fcm_pkg::KIND_W-1:0]        kind;
        logic [fcm_pkg::IDX_W-1:0]         idx;
        logic signed [fcm_pkg::VAL_W-1:0]  value;
        bit                                pinned;
        logic signed [fcm_pkg::OUT_W-1:0]  want;
    } t_vec_row;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               i_cfg_wr_en   = 1'b0;
    logic [fcm_pkg::CFG_W-1:0]          i_cfg_wr_data = '0;
    logic                               i_valid       = 1'b0;
    logic [fcm_pkg::KIND_W-1:0]         i_kind        = '0;
    logic [fcm_pkg::IDX_W-1:0]          i_tap_index   = '0;
    logic signed [fcm_pkg::VAL_W-1:0]   i_value       = '0;
    logic                               i_stall       = 1'b0;
    logic                               o_stall;
    logic                               o_valid;
    logic signed [fcm_pkg::OUT_W-1:0]   o_out_value;

    logic                               pin_en  = 1'b0;
    logic signed [fcm_pkg::OUT_W-1:0]   pin_val = '0;
    bit                                 idle_on = 1'b1;
    int                                 stall_left = 0;

    logic signed [fcm_pkg::VAL_W-1:0]   tap_mem  [MAX_TAPS];
    logic signed [fcm_pkg::VAL_W-1:0]   hist_mem [MAX_TAPS];
    logic [fcm_pkg::IDX_W-1:0]          hist_ptr = '0;
    logic [fcm_pkg::CFG_W-1:0]          taps_live = 11'd1;
    logic signed [fcm_pkg::OUT_W-1:0]   fir_sum_q [$];
    logic signed [fcm_pkg::OUT_W-1:0]   want;
    t_vec_row                           vec_rows [$];

    bit in_fire;
    bit out_fire;
    int quiet_cycles = 0;
    int n_err = 0;
    int n_samples = 0;
    int n_loads = 0;
    int n_clears = 0;
    int n_ignored = 0;
    int n_results = 0;
    int n_cfg = 0;

    fir_convolution_mac uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_kind        (i_kind),
        .i_tap_index   (i_tap_index),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_value   (o_out_value)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [fcm_pkg::OUT_W-1:0] push_and_sum(
        input logic signed [fcm_pkg::VAL_W-1:0] smp
    );
        logic signed [fcm_pkg::OUT_W-1:0] acc;
        logic [fcm_pkg::IDX_W-1:0]        pos;
        int                               n;
        acc = '0;
        pos = hist_ptr;
        hist_mem[pos] = smp;
        n = (taps_live > MAX_TAPS) ? MAX_TAPS : int'(taps_live);
        for (int k = 0; k < n; k++) begin
            acc = acc + tap_mem[k] * hist_mem[pos];
            pos = pos - 1'b1;
        end
        hist_ptr = hist_ptr + 1'b1;
        return acc;
    endfunction

    function automatic logic signed [fcm_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(
        input logic [fcm_pkg::KIND_W-1:0]         kind,
        input logic [fcm_pkg::IDX_W-1:0]          idx,
        input logic signed [fcm_pkg::VAL_W-1:0]   val,
        input bit                                 pin,
        input logic signed [fcm_pkg::OUT_W-1:0]   pinv
    );
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_tap_index <= idx;
        i_value     <= val;
        pin_en      <= pin;
        pin_val     <= pinv;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic write_tap_count(input logic [fcm_pkg::CFG_W-1:0] taps);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (fir_sum_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= taps;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!idle_on)
            stall_left = 0;
        else if (stall_left > 0)
            stall_left = stall_left - 1;
        else if ($urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 13);
        i_stall <= (stall_left != 0);
    end

    always @(posedge i_clk) begin
        in_fire  = i_rst_n && i_valid && !o_stall;
        out_fire = i_rst_n && o_valid && !i_stall;
        if (i_rst_n && i_cfg_wr_en) begin
            taps_live = i_cfg_wr_data;
            n_cfg++;
        end
        if (in_fire) begin
            case (i_kind)
                fcm_pkg::KIND_LOAD: begin
                    tap_mem[i_tap_index] = i_value;
                    n_loads++;
                end
                fcm_pkg::KIND_SAMPLE: begin
                    want = push_and_sum(i_value);
                    fir_sum_q.push_back(pin_en ? pin_val : want);
                    n_samples++;
                end
                fcm_pkg::KIND_CLEAR: begin
                    foreach (hist_mem[i]) hist_mem[i] = '0;
                    hist_ptr = '0;
                    n_clears++;
                end
                default: n_ignored++;
            endcase
        end
        if (out_fire) begin
            n_results++;
            if (fir_sum_q.size() == 0) begin
                n_err++;
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, o_out_value);
            end else begin
                want = fir_sum_q.pop_front();
                if (o_out_value !== want) begin
                    n_err++;
                    $display("%0t: out_value mismatch, expected %0d, actual %0d",
                             $time, want, o_out_value);
                end
            end
        end
        if (!i_rst_n || in_fire || out_fire)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int r;
        int taps;
        int act;
        int len;
        int big_phases;
        int rnd_items;
        logic [fcm_pkg::KIND_W-1:0] k;

        big_phases = 0;
        rnd_items  = 0;
        foreach (tap_mem[i]) tap_mem[i] = '0;
        foreach (hist_mem[i]) hist_mem[i] = '0;

        // Tap count is one after reset, so tap 0 is loaded before the first sample.
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_LOAD,   10'd0,    32767, 1'b0, 0});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_SAMPLE, 10'd0,    32767, 1'b1,
                             1073676289});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_SAMPLE, 10'd1023, -32768, 1'b1,
                             -1073709056});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_LOAD,   10'd0,    -32768, 1'b0, 0});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_SAMPLE, 10'd0,    -32768, 1'b1,
                             1073741824});
        vec_rows.push_back('{1'b0, 11'd0, KIND_IGNORED,         10'd1023, -1,     1'b0, 0});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_SAMPLE, 10'd0,    1,      1'b1,
                             -32768});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_LOAD,   10'd1,    32767,  1'b0, 0});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_LOAD,   10'd1023, -1,     1'b0, 0});
        vec_rows.push_back('{1'b1, 11'd0, fcm_pkg::KIND_LOAD,   10'd0,    0,      1'b0, 0});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_SAMPLE, 10'd0,    12345,  1'b1, 0});
        vec_rows.push_back('{1'b1, 11'd2, fcm_pkg::KIND_LOAD,   10'd0,    0,      1'b0, 0});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_SAMPLE, 10'd0,    0,      1'b0, 0});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_CLEAR,  10'd1023, -1,     1'b0, 0});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_SAMPLE, 10'd0,    100,    1'b1,
                             -3276800});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_SAMPLE, 10'd0,    -1,     1'b0, 0});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_LOAD,   10'd2,    21845,  1'b0, 0});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_LOAD,   10'd682,  -21846, 1'b0, 0});
        vec_rows.push_back('{1'b1, 11'd3, fcm_pkg::KIND_LOAD,   10'd0,    0,      1'b0, 0});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_SAMPLE, 10'd341,  21845,  1'b0, 0});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_SAMPLE, 10'd682,  -32768, 1'b0, 0});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_CLEAR,  10'd0,    0,      1'b0, 0});
        vec_rows.push_back('{1'b0, 11'd0, fcm_pkg::KIND_SAMPLE, 10'd0,    32767,  1'b0, 0});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (vec_rows[i]) begin
            if (vec_rows[i].cfg)
                write_tap_count(vec_rows[i].taps);
            else
                send_item(vec_rows[i].kind, vec_rows[i].idx, vec_rows[i].value,
                          vec_rows[i].pinned, vec_rows[i].want);
        end

        // Every tap is loaded once so that any tap count reads written taps only.
        for (int t = 0; t < MAX_TAPS; t++)
            send_item(fcm_pkg::KIND_LOAD, 10'(t), pick_value(), 1'b0, '0);

        write_tap_count(11'd2047);
        repeat (3) send_item(fcm_pkg::KIND_SAMPLE, 10'($urandom), pick_value(), 1'b0, '0);
        write_tap_count(11'd1024);
        repeat (2) send_item(fcm_pkg::KIND_SAMPLE, 10'($urandom), pick_value(), 1'b0, '0);
        send_item(fcm_pkg::KIND_CLEAR, 10'($urandom), pick_value(), 1'b0, '0);
        send_item(fcm_pkg::KIND_SAMPLE, 10'($urandom), pick_value(), 1'b0, '0);

        while (rnd_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                taps = 0;
            end else if (r == 1 && big_phases < 2) begin
                taps = $urandom_range(700, 2047);
                big_phases++;
            end else if (r < 5) begin
                taps = $urandom_range(33, 160);
            end else begin
                taps = $urandom_range(1, 32);
            end
            len = (taps > 160) ? 3 : $urandom_range(15, 45);
            idle_on = (rnd_items < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            write_tap_count(11'(taps));
            act = (taps > MAX_TAPS) ? MAX_TAPS : ((taps == 0) ? 1 : taps);
            repeat (len) begin
                r = $urandom_range(0, 99);
                if (r < 68)
                    k = fcm_pkg::KIND_SAMPLE;
                else if (r < 86)
                    k = fcm_pkg::KIND_LOAD;
                else if (r < 93)
                    k = fcm_pkg::KIND_CLEAR;
                else
                    k = KIND_IGNORED;
                if (k == fcm_pkg::KIND_LOAD && $urandom_range(0, 1) == 0)
                    send_item(k, 10'($urandom_range(0, act - 1)), pick_value(), 1'b0, '0);
                else
                    send_item(k, 10'($urandom), pick_value(), 1'b0, '0);
                if (k != KIND_IGNORED)
                    rnd_items++;
            end
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (fir_sum_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fir_sum_q.size() != 0) begin
            n_err++;
            $display("%0t: %0d expected results never arrived", $time, fir_sum_q.size());
        end

        $display("Stimulus: %0d samples, %0d tap loads, %0d clears, %0d unused-kind items, %0d tap-count writes.",
                 n_samples, n_loads, n_clears, n_ignored, n_cfg);
        $display("Compared %0d convolution sums, %0d mismatches.", n_results, n_err);
        if (n_err == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
